/* src/b4rcpu_pkg.sv */
`default_nettype none

package b4rcpu_pkg;

	localparam int unsigned NUM_REGS    = 4;
	localparam int unsigned REG_IDX_W   = $clog2(NUM_REGS);
	localparam int unsigned DATA_W      = 8;
	localparam int unsigned QUEUE_DEPTH = 2;

	// instruction groups of the 0xc0 page, taken from bits 7:2
	localparam logic [5:0] GRP_IN  = 6'h30;
	localparam logic [5:0] GRP_OUT = 6'h31;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_BAD     = 2'd1;
	localparam logic [1:0] ST_DIVZERO = 2'd2;
	localparam logic [1:0] ST_HALTED  = 2'd3;

	typedef enum logic [2:0] {
		CLS_MOVI,
		CLS_ALU,
		CLS_IN,
		CLS_OUT,
		CLS_BAD
	} cls_t;

	typedef enum logic [1:0] {
		OP_ADD,
		OP_SUB,
		OP_MUL,
		OP_DIV
	} op_t;

	typedef struct packed {
		logic [7:0] instruction_byte;
		logic [7:0] in_value;
	} in_req_t;

	typedef struct packed {
		logic       out_valid;
		logic [7:0] out_value;
		logic [1:0] status;
	} out_req_t;

	// decoded instruction as it sits in the queue
	typedef struct packed {
		cls_t                 cls;
		op_t                  op;
		logic [REG_IDX_W-1:0] rd;
		logic [REG_IDX_W-1:0] rs;
		logic [DATA_W-1:0]    data;
	} dec_t;

endpackage

`default_nettype wire

/* src/b4rcpu_ram.sv */
`default_nettype none

module b4rcpu_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 4
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
	output logic      [WIDTH-1:0]         rdata_a,
	input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic      [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_a <= mem_q[raddr_a];
		rdata_b <= mem_q[raddr_b];
	end

endmodule

`default_nettype wire

/* src/b4rcpu_front.sv */
`default_nettype none

module b4rcpu_front
	import b4rcpu_pkg::*;
(
	input  wire in_req_t instr,
	output dec_t         dec
);

	logic [7:0] b;

	assign b = instr.instruction_byte;

	always_comb begin
		dec.cls  = CLS_BAD;
		dec.op   = op_t'(b[5:4]);
		dec.rd   = b[3:2];
		dec.rs   = b[1:0];
		dec.data = b;
		if (!b[7]) begin
			dec.cls = CLS_MOVI;
		end else if (b[6]) begin
			if (b[7:2] == GRP_IN) begin
				dec.cls  = CLS_IN;
				dec.data = instr.in_value;
			end else if (b[7:2] == GRP_OUT) begin
				dec.cls = CLS_OUT;
			end else begin
				dec.cls = CLS_BAD;
			end
		end else begin
			dec.cls = CLS_ALU;
		end
	end

endmodule

`default_nettype wire

/* src/b4rcpu_queue.sv */
`default_nettype none

module b4rcpu_queue
	import b4rcpu_pkg::*;
#(
	parameter int unsigned DEPTH = QUEUE_DEPTH
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic wr,
	input  wire dec_t wdata,
	output logic      full,
	input  wire logic rd,
	output dec_t      head,
	output logic      empty
);

	localparam int unsigned AW = $clog2(DEPTH);

	dec_t          slot_q [DEPTH];
	logic [AW-1:0] wptr_q;
	logic [AW-1:0] rptr_q;
	logic [AW:0]   cnt_q;
	logic          do_wr;
	logic          do_rd;

	assign full  = (cnt_q == (AW+1)'(DEPTH));
	assign empty = (cnt_q == '0);
	assign head  = slot_q[rptr_q];
	assign do_wr = wr && !full;
	assign do_rd = rd && !empty;

	always_ff @(posedge clk) begin
		if (do_wr) begin
			slot_q[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_wr) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (do_rd) begin
				rptr_q <= rptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

/* src/b4rcpu_back.sv */
`default_nettype none

module b4rcpu_back
	import b4rcpu_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire dec_t q_head,
	input  wire logic q_empty,
	output logic      q_pop,
	input  wire logic pop,
	output out_req_t  result,
	output logic      empty
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_READ,
		S_DIV
	} state_t;

	state_t               state_q;
	dec_t                 ent_q;
	logic                 halted_q;
	logic [NUM_REGS-1:0]  rf_vld_q;
	out_req_t             out_q;
	logic                 out_full_q;
	logic [DATA_W-1:0]    rem_q;
	logic [DATA_W-1:0]    quo_q;
	logic [DATA_W-1:0]    dvs_q;
	logic [2:0]           cnt_q;

	logic                 we;
	logic [REG_IDX_W-1:0] waddr;
	logic [DATA_W-1:0]    wdata;
	logic [REG_IDX_W-1:0] raddr_a;
	logic [REG_IDX_W-1:0] raddr_b;
	logic [DATA_W-1:0]    rdata_a;
	logic [DATA_W-1:0]    rdata_b;
	logic [DATA_W-1:0]    opa;
	logic [DATA_W-1:0]    opb;
	logic [2*DATA_W-1:0]  prod;
	logic [DATA_W-1:0]    alu_res;
	logic [DATA_W:0]      trial;
	logic [DATA_W-1:0]    rem_next;
	logic [DATA_W-1:0]    quo_next;
	logic                 slot_free;
	out_req_t             exe_res;
	logic                 exe_div;
	logic                 exe_halt;

	b4rcpu_ram #(
		.WIDTH(DATA_W),
		.DEPTH(NUM_REGS)
	) u_rf (
		.clk    (clk),
		.we     (we),
		.waddr  (waddr),
		.wdata  (wdata),
		.raddr_a(raddr_a),
		.rdata_a(rdata_a),
		.raddr_b(raddr_b),
		.rdata_b(rdata_b)
	);

	assign raddr_a   = q_head.rd;
	assign raddr_b   = q_head.rs;
	assign opa       = rf_vld_q[ent_q.rd] ? rdata_a : '0;
	assign opb       = rf_vld_q[ent_q.rs] ? rdata_b : '0;
	assign prod      = opa * opb;
	assign slot_free = !out_full_q || pop;
	assign result    = out_q;
	assign empty     = !out_full_q;

	// one restoring divide step
	assign trial    = {rem_q, quo_q[DATA_W-1]} - {1'b0, dvs_q};
	assign rem_next = trial[DATA_W] ? {rem_q[DATA_W-2:0], quo_q[DATA_W-1]} : trial[DATA_W-1:0];
	assign quo_next = {quo_q[DATA_W-2:0], !trial[DATA_W]};

	always_comb begin
		unique case (ent_q.op)
			OP_ADD:  alu_res = opa + opb;
			OP_SUB:  alu_res = opa - opb;
			OP_MUL:  alu_res = prod[DATA_W-1:0];
			OP_DIV:  alu_res = '0;
			default: alu_res = '0;
		endcase
	end

	// result and side effects of the execute cycle
	always_comb begin
		exe_res        = '0;
		exe_res.status = ST_OK;
		exe_div        = 1'b0;
		exe_halt       = 1'b0;
		if (halted_q) begin
			exe_res.status = ST_HALTED;
		end else begin
			unique case (ent_q.cls)
				CLS_OUT: begin
					exe_res.out_valid = 1'b1;
					exe_res.out_value = opb;
				end
				CLS_BAD: begin
					exe_halt       = 1'b1;
					exe_res.status = ST_BAD;
				end
				CLS_ALU: begin
					if (ent_q.op == OP_DIV) begin
						if (opb == '0) begin
							exe_halt       = 1'b1;
							exe_res.status = ST_DIVZERO;
						end else begin
							exe_div = 1'b1;
						end
					end
				end
				default: begin
					exe_res.status = ST_OK;
				end
			endcase
		end
	end

	always_comb begin
		q_pop = (state_q == S_IDLE) && !q_empty && slot_free;
		we    = 1'b0;
		waddr = ent_q.rd;
		wdata = alu_res;
		if (state_q == S_READ && !halted_q) begin
			unique case (ent_q.cls)
				CLS_MOVI: begin
					we    = 1'b1;
					waddr = REG_IDX_W'(NUM_REGS - 1);
					wdata = ent_q.data;
				end
				CLS_IN: begin
					we    = 1'b1;
					waddr = ent_q.rs;
					wdata = ent_q.data;
				end
				CLS_ALU: begin
					we = (ent_q.op != OP_DIV);
				end
				default: begin
					we = 1'b0;
				end
			endcase
		end else if (state_q == S_DIV && cnt_q == 3'd7) begin
			we    = 1'b1;
			wdata = quo_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			ent_q      <= '0;
			halted_q   <= 1'b0;
			rf_vld_q   <= '0;
			out_q      <= '0;
			out_full_q <= 1'b0;
			rem_q      <= '0;
			quo_q      <= '0;
			dvs_q      <= '0;
			cnt_q      <= '0;
		end else begin
			if (pop && out_full_q) begin
				out_full_q <= 1'b0;
			end
			if (we) begin
				rf_vld_q[waddr] <= 1'b1;
			end
			unique case (state_q)
				S_IDLE: begin
					if (q_pop) begin
						ent_q   <= q_head;
						state_q <= S_READ;
					end
				end
				S_READ: begin
					// a divide posts its result when the divider ends
					out_q      <= exe_res;
					out_full_q <= !exe_div;
					state_q    <= exe_div ? S_DIV : S_IDLE;
					if (exe_halt) begin
						halted_q <= 1'b1;
					end
					if (exe_div) begin
						rem_q <= '0;
						quo_q <= opa;
						dvs_q <= opb;
						cnt_q <= '0;
					end
				end
				S_DIV: begin
					rem_q <= rem_next;
					quo_q <= quo_next;
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == 3'd7) begin
						out_full_q      <= 1'b1;
						out_q.out_valid <= 1'b0;
						out_q.out_value <= '0;
						out_q.status    <= ST_OK;
						state_q         <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

/* src/byte_isa_four_register_cpu_core.sv */
// channel   | handshake        | payload (packed struct)          | direction
// ----------+------------------+----------------------------------+----------
// request   | push / full      | instr: instruction_byte,in_value | into core
// result    | pop / empty      | result: out_valid,out_value,     | out of core
//           |                  |         status                   |
//
// a request enters the decode queue on the edge it is taken and leaves it
// once the execute side is idle and the result slot has room; the execute
// side handles it in two steps (queue pop with register-file read, then
// execute) and pops no new request until the current one is executed
// a divide adds the steps of the one-bit-a-cycle shift-subtract divider,
// one per quotient bit, before its result is posted
// arst_n clears the queue, the register-file valid bits (registers read as
// zero until written), the halt flag and the result slot
// a full result slot stalls only the execute side; the queue keeps taking
// requests until it fills, and then full holds off the sender
`default_nettype none

module byte_isa_four_register_cpu_core
	import b4rcpu_pkg::*;
#(
	parameter int unsigned QUEUE_DEPTH = b4rcpu_pkg::QUEUE_DEPTH
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    push,
	output logic         full,
	input  wire in_req_t instr,
	output logic         empty,
	input  wire logic    pop,
	output out_req_t     result
);

	// decoded request on its way into the queue
	dec_t dec;
	// oldest decoded request, seen by the execute side
	dec_t q_head;
	logic q_empty;
	logic q_pop;

	// classify the byte: movi, alu op, in, out or illegal
	b4rcpu_front u_front (
		.instr(instr),
		.dec  (dec)
	);

	// short queue that decouples decode from execute
	b4rcpu_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.wr    (push),
		.wdata (dec),
		.full  (full),
		.rd    (q_pop),
		.head  (q_head),
		.empty (q_empty)
	);

	// register file, alu, divider, halt flag and result slot
	b4rcpu_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.q_head (q_head),
		.q_empty(q_empty),
		.q_pop  (q_pop),
		.pop    (pop),
		.result (result),
		.empty  (empty)
	);

endmodule

`default_nettype wire

/* src/b4rcpu_chk.sv */
`default_nettype none

module b4rcpu_chk
	import b4rcpu_pkg::*;
(
	input wire logic     clk,
	input wire logic     arst_n,
	input wire logic     push,
	input wire logic     full,
	input wire in_req_t  instr,
	input wire logic     empty,
	input wire logic     pop,
	input wire out_req_t result
);

	// nothing is offered while in reset
	a_reset_empty: assert property (@(posedge clk) !arst_n |-> empty)
		else $error("result offered during reset");

	// only an out instruction that completes normally carries a value
	a_valid_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.out_valid) |-> (result.status == ST_OK))
		else $error("out_valid with error status");

	a_value_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !result.out_valid) |-> (result.out_value == '0))
		else $error("out_value nonzero without out_valid");

	// a result that is not taken stays as it is
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(result)))
		else $error("waiting result changed");

endmodule

bind byte_isa_four_register_cpu_core b4rcpu_chk u_chk (.*);

`default_nettype wire

/* bench/byte_isa_four_register_cpu_core_tb.sv */
`default_nettype none

module byte_isa_four_register_cpu_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import b4rcpu_pkg::*;

	// register indexes as the instruction encodes them
	localparam logic [1:0] REG_A = 2'd0;
	localparam logic [1:0] REG_B = 2'd1;
	localparam logic [1:0] REG_C = 2'd2;
	localparam logic [1:0] REG_D = 2'd3;

	localparam int RANDOM_REQUESTS = 1200;
	localparam int AFTER_HALT      = 40;
	localparam int IDLE_PCT        = 35;
	localparam int CALM_FROM       = 500;   // no idling on either side in this window
	localparam int CALM_TO         = 700;
	localparam int HOLD_AT         = 250;   // results seen when the receiver holds off
	localparam int HOLD_CYCLES     = 80;
	localparam int DRAIN_AT        = 900;   // random request that waits for an empty pipe
	localparam int STALL_LIMIT     = 1000;  // cycles with no handshake at all
	localparam int TAIL_CYCLES     = 30;    // room for a final divide, plus queue slack

	// architectural state of the core: four registers and the sticky halt
	typedef struct packed {
		logic [3:0][7:0] regs;
		logic            halted;
	} cpu_state_t;

	// one pending request; drain_first holds it back until nothing is outstanding
	typedef struct packed {
		in_req_t req;
		logic    drain_first;
	} pend_t;

	logic     clk    = 1'b0;
	logic     arst_n = 1'b1;
	logic     push   = 1'b0;
	logic     pop    = 1'b0;
	in_req_t  instr  = '0;
	logic     full;
	logic     empty;
	out_req_t result;

	byte_isa_four_register_cpu_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.instr  (instr),
		.empty  (empty),
		.pop    (pop),
		.result (result)
	);

	pend_t      send_q[$];     // requests waiting for the driver
	out_req_t   expect_q[$];   // predicted results, oldest first
	cpu_state_t plan_cpu;      // state as the generator sees it, to steer divides
	cpu_state_t exec_cpu;      // state advanced on every accepted request

	int    requests_taken  = 0;
	int    results_checked = 0;
	int    outs_checked    = 0;
	int    mismatches      = 0;
	int    stall_cycles    = 0;
	int    hold_left       = 0;
	bit    hold_done       = 1'b0;
	string halt_kind;

	wire calm = (requests_taken >= CALM_FROM) && (requests_taken < CALM_TO);

	initial forever #10 clk = ~clk;

	// executes one instruction on st and returns the result it reports
	function automatic out_req_t run_instr(inout cpu_state_t st, input in_req_t req);
		out_req_t   r;
		logic [1:0] rd;
		logic [1:0] rs;
		logic [7:0] a;
		logic [7:0] b;
		op_t        op;
		r        = '0;
		r.status = ST_OK;
		rs       = req.instruction_byte[1:0];
		rd       = req.instruction_byte[3:2];
		op       = op_t'(req.instruction_byte[5:4]);
		if (st.halted) begin
			// nothing moves until reset
			r.status = ST_HALTED;
		end else if (!req.instruction_byte[7]) begin
			// immediate load always lands in D
			st.regs[REG_D] = req.instruction_byte;
		end else if (req.instruction_byte[6]) begin
			if (req.instruction_byte[7:2] == GRP_IN) begin
				st.regs[rs] = req.in_value;
			end else if (req.instruction_byte[7:2] == GRP_OUT) begin
				r.out_valid = 1'b1;
				r.out_value = st.regs[rs];
			end else begin
				st.halted = 1'b1;
				r.status  = ST_BAD;
			end
		end else begin
			a = st.regs[rd];
			b = st.regs[rs];
			case (op)
				OP_ADD: st.regs[rd] = a + b;
				OP_SUB: st.regs[rd] = a - b;
				OP_MUL: st.regs[rd] = a * b;
				default: begin
					// zero divisor keeps rd and halts
					if (b == 8'd0) begin
						st.halted = 1'b1;
						r.status  = ST_DIVZERO;
					end else begin
						st.regs[rd] = a / b;
					end
				end
			endcase
		end
		return r;
	endfunction

	function automatic logic [7:0] alu_byte(op_t op, logic [1:0] rd, logic [1:0] rs);
		return {2'b10, op, rd, rs};
	endfunction

	// appends a request and advances the planning copy of the core
	task automatic queue_instr(logic [7:0] ib, logic [7:0] iv, logic drain = 1'b0);
		pend_t p;
		p.req.instruction_byte = ib;
		p.req.in_value         = iv;
		p.drain_first          = drain;
		void'(run_instr(plan_cpu, p.req));
		send_q.push_back(p);
	endtask

	task automatic report_mismatch(string what, out_req_t exp, out_req_t got);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t: %s: expected valid %0b value %02h status %0d,",
				$realtime, what, exp.out_valid, exp.out_value, exp.status,
				" got valid %0b value %02h status %0d",
				got.out_valid, got.out_value, got.status);
	endtask

	// driver: offers the head of send_q, holds it steady while full is high
	always @(posedge clk or negedge arst_n) begin : drive_requests
		pend_t nxt;
		bit    go;
		if (!arst_n) begin
			push  <= 1'b0;
			instr <= '0;
		end else begin
			if (push && !full) begin
				expect_q.push_back(run_instr(exec_cpu, instr));
				requests_taken++;
			end
			if (!push || !full) begin
				go = 1'b0;
				if (send_q.size() != 0) begin
					nxt = send_q[0];
					go  = (calm || $urandom_range(0, 99) >= IDLE_PCT) &&
						!(nxt.drain_first && expect_q.size() != 0);
				end
				if (go) begin
					nxt   = send_q.pop_front();
					instr <= nxt.req;
					push  <= 1'b1;
				end else begin
					push <= 1'b0;
				end
			end
		end
	end

	// monitor: takes results, checks them against the oldest prediction
	always @(posedge clk or negedge arst_n) begin : take_results
		out_req_t exp;
		out_req_t got;
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			if (pop && !empty) begin
				got = result;
				if (expect_q.size() == 0) begin
					report_mismatch("result with no request outstanding", '0, got);
				end else begin
					exp = expect_q.pop_front();
					results_checked++;
					if (exp.out_valid)
						outs_checked++;
					if (got.out_valid !== exp.out_valid || got.out_value !== exp.out_value ||
						got.status !== exp.status)
						report_mismatch("result mismatch", exp, got);
				end
			end
			// one long hold-off so the queue fills and full pushes back
			if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				pop       <= 1'b0;
			end else if (!hold_done && results_checked == HOLD_AT) begin
				hold_done <= 1'b1;
				hold_left <= HOLD_CYCLES;
				pop       <= 1'b0;
			end else begin
				pop <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
			end
		end
	end

	// watchdog on cycles where neither side moves a request or a result
	always @(posedge clk) begin
		if (arst_n) begin
			if ((push && !full) || (pop && !empty)) begin
				stall_cycles <= 0;
			end else if (stall_cycles >= STALL_LIMIT) begin
				$display("timeout: no handshake for %0d cycles", STALL_LIMIT);
				$display("Testbench completed WITH ERRORS");
				$finish;
			end else begin
				stall_cycles <= stall_cycles + 1;
			end
		end
	end

	initial begin : stimulus
		int         k;
		logic [1:0] rd;
		logic [1:0] rs;
		op_t        op;
		arst_n   <= 1'b0;
		plan_cpu = '0;
		exec_cpu = '0;

		// directed: reset contents, immediate extremes, IN extremes,
		// wrapping add/sub/mul, divides including rd equal to rs
		queue_instr({GRP_OUT, REG_A}, 8'hff);
		queue_instr({GRP_OUT, REG_D}, 8'h00);
		queue_instr(8'h00, 8'hff);
		queue_instr(8'h7f, 8'h00);
		queue_instr({GRP_IN, REG_A}, 8'hff);
		queue_instr({GRP_IN, REG_B}, 8'h01);
		queue_instr({GRP_IN, REG_C}, 8'h80);
		queue_instr(alu_byte(OP_ADD, REG_A, REG_B), 8'h00);
		queue_instr({GRP_OUT, REG_A}, 8'h00);
		queue_instr(alu_byte(OP_SUB, REG_A, REG_B), 8'h00);
		queue_instr({GRP_OUT, REG_A}, 8'h00);
		queue_instr(alu_byte(OP_MUL, REG_C, REG_D), 8'h00);
		queue_instr({GRP_OUT, REG_C}, 8'h00);
		queue_instr(alu_byte(OP_MUL, REG_A, REG_A), 8'h00);
		queue_instr({GRP_OUT, REG_A}, 8'h00);
		queue_instr(alu_byte(OP_DIV, REG_A, REG_B), 8'h00);
		queue_instr(alu_byte(OP_DIV, REG_D, REG_C), 8'h00);
		queue_instr({GRP_OUT, REG_D}, 8'h00);
		queue_instr(alu_byte(OP_DIV, REG_C, REG_C), 8'h00);
		queue_instr({GRP_OUT, REG_C}, 8'h00);
		queue_instr({GRP_OUT, REG_B}, 8'h00);

		// random well-formed program; divides by a zero register are turned
		// into another operation so the core stays live until the end
		for (int i = 0; i < RANDOM_REQUESTS; i++) begin
			k  = $urandom_range(0, 99);
			rd = $urandom_range(0, 3);
			rs = $urandom_range(0, 3);
			if (k < 15) begin
				queue_instr({1'b0, 7'($urandom_range(0, 127))}, 8'($urandom), i == DRAIN_AT);
			end else if (k < 32) begin
				queue_instr({GRP_IN, rs}, 8'($urandom), i == DRAIN_AT);
			end else if (k < 57) begin
				queue_instr({GRP_OUT, rs}, 8'($urandom), i == DRAIN_AT);
			end else begin
				op = op_t'($urandom_range(0, 3));
				if (op == OP_DIV && plan_cpu.regs[rs] == 8'd0)
					op = op_t'($urandom_range(0, 2));
				queue_instr(alu_byte(op, rd, rs), 8'($urandom), i == DRAIN_AT);
			end
		end

		// halt the core once, by a bad opcode or by a zero divisor
		rs = $urandom_range(0, 3);
		if ($urandom_range(0, 1) == 0) begin
			halt_kind = "bad instruction";
			queue_instr(8'($urandom_range(8'hc8, 8'hff)), 8'($urandom));
		end else begin
			halt_kind = "divide by zero";
			queue_instr({GRP_IN, rs}, 8'h00);
			queue_instr(alu_byte(OP_DIV, 2'($urandom_range(0, 3)), rs), 8'($urandom));
		end
		// everything after the halt is answered as halted, any byte at all
		queue_instr(8'hff, 8'hff);
		for (int i = 0; i < AFTER_HALT; i++)
			queue_instr(8'($urandom), 8'($urandom));

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		while (send_q.size() != 0 || push)
			@(posedge clk);
		while (expect_q.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("%0d requests through a random four-register program,", requests_taken,
			" %0d results checked, %0d OUT values", results_checked, outs_checked);
		$display("halt raised by %s, then %0d requests answered as halted, mismatches %0d",
			halt_kind, AFTER_HALT + 1, mismatches);
		if (mismatches == 0 && expect_q.size() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

`default_nettype wire
